/* sv/gfmac_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the gf(2^m) multiply-accumulate block
package gfmac_pkg;

  localparam int unsigned ElemW  = 48;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned PpW    = 2 * HalfW - 1;
  localparam int unsigned AccW   = 2 * ElemW - 1;
  localparam int unsigned SelW   = 2;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [PpW-1:0]   pp_t;
  typedef logic [AccW-1:0]  acc_t;
  typedef logic [SelW-1:0]  field_sel_t;

  // partial products of a 24-bit split: ll, lh, hl, hh
  typedef struct packed {
    pp_t hh;
    pp_t hl;
    pp_t lh;
    pp_t ll;
  } pp_set_t;

  localparam field_sel_t FIELD_16 = 2'd0;
  localparam field_sel_t FIELD_32 = 2'd1;
  localparam field_sel_t FIELD_40 = 2'd2;
  localparam field_sel_t FIELD_48 = 2'd3;

  localparam logic [3:0][ElemW-1:0] FIELD_MASK = {
    48'hFFFF_FFFF_FFFF,
    48'h00FF_FFFF_FFFF,
    48'h0000_FFFF_FFFF,
    48'h0000_0000_FFFF
  };

endpackage

/* sv/gf2m_multiply_accumulate.sv */
`timescale 1ns / 1ps
// gf(2^m) multiply-accumulate: operand register, partial products, accumulate, fold
// a last item's result passes operand, partial-product, sum and result registers
// one item per cycle unless stalled; the accumulator feedback is a single xor
// a stalled result holds the output register and backs up one stage at a time
// reset (synchronous, active low) clears all stage valids, the accumulator
// and selects the 16-bit field
module gf2m_multiply_accumulate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gfmac_pkg::elem_t             in_op_a,
  input  gfmac_pkg::elem_t             in_op_b,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gfmac_pkg::elem_t             out_product,
  input  logic                         cfg_we,
  input  gfmac_pkg::field_sel_t        cfg_wdata
);

  localparam int unsigned H = gfmac_pkg::HalfW;

  gfmac_pkg::field_sel_t field_sel_r;

  logic               v1_r;
  gfmac_pkg::elem_t   a1_r;
  gfmac_pkg::elem_t   b1_r;
  logic               last1_r;

  logic               v2_r;
  gfmac_pkg::pp_set_t pp2_r;
  logic               last2_r;

  gfmac_pkg::acc_t    acc_r;

  logic               v3_r;
  gfmac_pkg::acc_t    sum3_r;

  logic               out_valid_r;
  gfmac_pkg::elem_t   out_product_r;

  gfmac_pkg::pp_set_t pp_nxt;
  gfmac_pkg::acc_t    prod2;
  gfmac_pkg::acc_t    sum2;
  gfmac_pkg::elem_t   fold_res;
  gfmac_pkg::elem_t   mask;

  logic out_free, mv3, s3_free, mv2, s2_free, mv1, in_acc;

  // stage handshake chain, back to front
  assign out_free = !out_valid_r || out_ready;
  assign mv3      = v3_r && out_free;
  assign s3_free  = !v3_r || mv3;
  assign mv2      = v2_r && (!last2_r || s3_free);
  assign s2_free  = !v2_r || mv2;
  assign mv1      = v1_r && s2_free;
  assign in_ready = !v1_r || mv1;
  assign in_acc   = in_valid && in_ready;

  assign mask = gfmac_pkg::FIELD_MASK[field_sel_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_sel_r <= gfmac_pkg::FIELD_16;
    end else if (cfg_we) begin
      field_sel_r <= cfg_wdata;
    end
  end

  // stage 1: masked operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (mv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a1_r    <= in_op_a & mask;
      b1_r    <= in_op_b & mask;
      last1_r <= in_last;
    end
  end

  gfmac_pp u_pp (
    .a  (a1_r),
    .b  (b1_r),
    .pp (pp_nxt)
  );

  // stage 2: partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (mv1) begin
      v2_r <= 1'b1;
    end else if (mv2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      pp2_r   <= pp_nxt;
      last2_r <= last1_r;
    end
  end

  assign prod2 = ({{(gfmac_pkg::AccW - gfmac_pkg::PpW){1'b0}}, pp2_r.hh} << (2 * H))
               ^ ({{(gfmac_pkg::AccW - gfmac_pkg::PpW){1'b0}}, pp2_r.hl ^ pp2_r.lh} << H)
               ^ {{(gfmac_pkg::AccW - gfmac_pkg::PpW){1'b0}}, pp2_r.ll};
  assign sum2  = acc_r ^ prod2;

  // accumulator, cleared as a last item moves on to the fold stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (mv2) begin
      acc_r <= last2_r ? '0 : sum2;
    end
  end

  // stage 3: completed sum awaiting reduction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (mv2 && last2_r) begin
      v3_r <= 1'b1;
    end else if (mv3) begin
      v3_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2 && last2_r) begin
      sum3_r <= sum2;
    end
  end

  gfmac_fold u_fold (
    .acc       (sum3_r),
    .field_sel (field_sel_r),
    .product   (fold_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mv3) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      out_product_r <= fold_res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (mv2 && last2_r) |=> (acc_r == '0))
    else $error("accumulator not cleared after a last item");

  a_out_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !cfg_we) |-> ((out_product_r & ~mask) == '0))
    else $error("result has bits above the field width");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !mv3)
    else $error("fold stage loaded a held result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r && !out_valid_r))
    else $error("pipeline not idle after reset");

endmodule

/* sv/gfmac_pp.sv */
`timescale 1ns / 1ps
// carry-less partial products of two 48-bit operands over 24-bit halves
module gfmac_pp (
  input  gfmac_pkg::elem_t   a,
  input  gfmac_pkg::elem_t   b,
  output gfmac_pkg::pp_set_t pp
);

  function automatic gfmac_pkg::pp_t clmul_half(
    input logic [gfmac_pkg::HalfW-1:0] x,
    input logic [gfmac_pkg::HalfW-1:0] y
  );
    gfmac_pkg::pp_t r;
    r = '0;
    for (int i = 0; i < gfmac_pkg::HalfW; i++) begin
      if (y[i]) begin
        r = r ^ ({{(gfmac_pkg::PpW - gfmac_pkg::HalfW){1'b0}}, x} << i);
      end
    end
    return r;
  endfunction

  localparam int unsigned H = gfmac_pkg::HalfW;

  always_comb begin
    pp.ll = clmul_half(a[H-1:0],   b[H-1:0]);
    pp.lh = clmul_half(a[H-1:0],   b[2*H-1:H]);
    pp.hl = clmul_half(a[2*H-1:H], b[H-1:0]);
    pp.hh = clmul_half(a[2*H-1:H], b[2*H-1:H]);
  end

endmodule

/* sv/gfmac_fold.sv */
`timescale 1ns / 1ps
// two-fold shift/xor reduction of the accumulator to the selected field
module gfmac_fold (
  input  gfmac_pkg::acc_t       acc,
  input  gfmac_pkg::field_sel_t field_sel,
  output gfmac_pkg::elem_t      product
);

  logic [63:0] lo;
  logic [63:0] hi;
  logic [63:0] up;
  logic [63:0] t;
  logic [63:0] up2;
  logic [63:0] r;

  assign lo = acc[63:0];
  assign hi = {33'd0, acc[94:64]};

  always_comb begin
    unique case (field_sel)
      gfmac_pkg::FIELD_16: begin
        up  = lo >> 16;
        t   = up;
        up2 = up ^ (t >> 11) ^ (t >> 13) ^ (t >> 15);
        r   = lo ^ (up2 << 5) ^ (up2 << 3) ^ (up2 << 1) ^ up2;
      end
      gfmac_pkg::FIELD_32: begin
        up  = lo >> 32;
        t   = up;
        up2 = up ^ (t >> 25) ^ (t >> 29) ^ (t >> 30);
        r   = lo ^ (up2 << 7) ^ (up2 << 3) ^ (up2 << 2) ^ up2;
      end
      gfmac_pkg::FIELD_40: begin
        up  = ((hi & 64'hFFFF) << 24) | (lo >> 40);
        t   = up;
        up2 = up ^ (t >> 35) ^ (t >> 36) ^ (t >> 37);
        r   = lo ^ (up2 << 5) ^ (up2 << 4) ^ (up2 << 3) ^ up2;
      end
      default: begin
        up  = ((hi & 64'hFFFF_FFFF) << 16) | (lo >> 48);
        t   = up;
        up2 = up ^ (t >> 43) ^ (t >> 45) ^ (t >> 46);
        r   = lo ^ (up2 << 5) ^ (up2 << 3) ^ (up2 << 2) ^ up2;
      end
    endcase
  end

  assign product = r[gfmac_pkg::ElemW-1:0] & gfmac_pkg::FIELD_MASK[field_sel];

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the gf(2^m) multiply-accumulate block
module tb;

  typedef struct {
    gfmac_pkg::elem_t op_a;
    gfmac_pkg::elem_t op_b;
    logic             last;
  } pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  gfmac_pkg::elem_t      in_op_a = '0;
  gfmac_pkg::elem_t      in_op_b = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gfmac_pkg::elem_t      out_product;
  logic                  cfg_we = 1'b0;
  gfmac_pkg::field_sel_t cfg_wdata = gfmac_pkg::FIELD_16;

  // predictor state
  gfmac_pkg::field_sel_t cur_field = gfmac_pkg::FIELD_16;
  gfmac_pkg::acc_t       mac_acc = '0;

  pair_t            pending_pairs[$];
  gfmac_pkg::elem_t expected_products[$];
  int               queued_count = 0;
  int               taken_count = 0;
  int               fail_count = 0;
  int               idle_pct = 20;
  int               gap_left = 0;
  int               stall_left = 0;
  pair_t            next_pair;
  gfmac_pkg::elem_t want;

  gf2m_multiply_accumulate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op_a    (in_op_a),
    .in_op_b    (in_op_b),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_product(out_product),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic gfmac_pkg::acc_t clmul(gfmac_pkg::elem_t a, gfmac_pkg::elem_t b);
    gfmac_pkg::acc_t p;
    p = '0;
    for (int i = 0; i < gfmac_pkg::ElemW; i++) begin
      if (b[i]) p ^= gfmac_pkg::acc_t'(a) << i;
    end
    return p;
  endfunction

  // two-fold reduction; only the accumulator bits the field's network looks at
  function automatic gfmac_pkg::elem_t fold_acc(gfmac_pkg::field_sel_t sel,
                                                gfmac_pkg::acc_t acc);
    logic [63:0] lo, up, t, r;
    int unsigned m, t1, t2, t3;
    lo = acc[63:0];
    case (sel)
      gfmac_pkg::FIELD_16: begin
        m = 16; t1 = 5; t2 = 3; t3 = 1;
        up = 64'(acc[63:16]);
      end
      gfmac_pkg::FIELD_32: begin
        m = 32; t1 = 7; t2 = 3; t3 = 2;
        up = 64'(acc[63:32]);
      end
      gfmac_pkg::FIELD_40: begin
        m = 40; t1 = 5; t2 = 4; t3 = 3;
        up = 64'(acc[79:40]);
      end
      default: begin
        m = 48; t1 = 5; t2 = 3; t3 = 2;
        up = 64'(acc[94:48]);
      end
    endcase
    t = up;
    up = up ^ (t >> (m - t1)) ^ (t >> (m - t2)) ^ (t >> (m - t3));
    r = lo ^ (up << t1) ^ (up << t2) ^ (up << t3) ^ up;
    return gfmac_pkg::elem_t'(r) & gfmac_pkg::FIELD_MASK[sel];
  endfunction

  task automatic accumulate_pair(gfmac_pkg::elem_t a, gfmac_pkg::elem_t b, logic last);
    gfmac_pkg::elem_t mask;
    mask = gfmac_pkg::FIELD_MASK[cur_field];
    mac_acc ^= clmul(a & mask, b & mask);
    if (last) begin
      expected_products = {expected_products, fold_acc(cur_field, mac_acc)};
      mac_acc = '0;
    end
  endtask

  function automatic gfmac_pkg::elem_t rand_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return gfmac_pkg::elem_t'(1) << $urandom_range(0, gfmac_pkg::ElemW - 1);
      default: return gfmac_pkg::elem_t'({$urandom, $urandom});
    endcase
  endfunction

  task automatic queue_pair(gfmac_pkg::elem_t a, gfmac_pkg::elem_t b, logic last);
    pair_t p;
    p.op_a = a;
    p.op_b = b;
    p.last = last;
    pending_pairs = {pending_pairs, p};
    queued_count++;
  endtask

  task automatic queue_random_runs(int n_items);
    int left;
    int run_len;
    left = n_items;
    while (left > 0) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      if (run_len > left) run_len = left;
      for (int i = 0; i < run_len; i++)
        queue_pair(rand_operand(), rand_operand(), i == run_len - 1);
      left -= run_len;
    end
    // sometimes leave a run open so the next field setting inherits it
    if ($urandom_range(0, 1) == 1) queue_pair(rand_operand(), rand_operand(), 1'b0);
  endtask

  task automatic queue_corners(gfmac_pkg::field_sel_t sel);
    gfmac_pkg::elem_t mask;
    gfmac_pkg::elem_t top;
    mask = gfmac_pkg::FIELD_MASK[sel];
    top = mask ^ (mask >> 1);
    queue_pair('1, '1, 1'b1);
    queue_pair('0, '1, 1'b1);
    queue_pair(gfmac_pkg::elem_t'(1), rand_operand(), 1'b1);
    queue_pair(top, top, 1'b1);
    queue_pair('1, '1, 1'b0);
    queue_pair(top, mask, 1'b1);
  endtask

  // all items taken, all results back, then let the pipe empty
  task automatic wait_drained();
    while (taken_count != queued_count || expected_products.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_field(gfmac_pkg::field_sel_t sel);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_field = sel;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_pair(in_op_a, in_op_b, in_last);
        taken_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          next_pair = pending_pairs.pop_front();
          in_op_a <= next_pair.op_a;
          in_op_b <= next_pair.op_b;
          in_last <= next_pair.last;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_products.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: product %h arrived with nothing pending", $time, out_product);
        end else begin
          want = expected_products.pop_front();
          if (out_product !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: product mismatch, expected %h got %h", $time, want, out_product);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    gfmac_pkg::field_sel_t phase_field [12];
    phase_field = '{gfmac_pkg::FIELD_48, gfmac_pkg::FIELD_32, gfmac_pkg::FIELD_16,
                    gfmac_pkg::FIELD_40, gfmac_pkg::FIELD_40, gfmac_pkg::FIELD_48,
                    gfmac_pkg::FIELD_16, gfmac_pkg::FIELD_32, gfmac_pkg::FIELD_48,
                    gfmac_pkg::FIELD_40, gfmac_pkg::FIELD_32, gfmac_pkg::FIELD_16};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corner operands in every field, the first under the reset setting
    queue_corners(gfmac_pkg::FIELD_16);
    wait_drained();
    set_field(gfmac_pkg::FIELD_48);
    queue_corners(gfmac_pkg::FIELD_48);
    wait_drained();
    set_field(gfmac_pkg::FIELD_32);
    queue_corners(gfmac_pkg::FIELD_32);
    wait_drained();
    set_field(gfmac_pkg::FIELD_40);
    queue_corners(gfmac_pkg::FIELD_40);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      // a stretch with no idling mid-run, and none at all in the final phase
      idle_pct = (p == 5 || p == 11) ? 0 : ((p % 2 == 1) ? 40 : 15);
      set_field(phase_field[p]);
      queue_random_runs(128);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("[gf2m_multiply_accumulate] OK");
    end else begin
      $display("[gf2m_multiply_accumulate] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[gf2m_multiply_accumulate] ERROR");
    $finish;
  end

endmodule

/* gf2m_multiply_accumulate.f */
sv/gfmac_pkg.sv
sv/gfmac_pp.sv
sv/gfmac_fold.sv
sv/gf2m_multiply_accumulate.sv
tb/tb.sv
